// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked while reset is held.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/icmperc_pkg.sv =====
package icmperc_pkg;

    // Verdict codes, in the order the checks are applied.
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_SHORT      = 3'd1,
        ST_TRUNCATED  = 3'd2,
        ST_CHECKSUM   = 3'd3,
        ST_NOT_REPLY  = 3'd4,
        ST_FOREIGN_ID = 3'd5
    } t_status;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_ID     = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_ICMP_LENGTH = 1'd1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [16:0] POS_MAX      = 17'h1FFFF;
    localparam logic [6:0]  MIN_LEN_RST  = 7'd8;
    localparam logic [16:0] SUM_GOOD     = 17'h0FFFF;
    localparam logic [7:0]  TYPE_ECHO_REPLY = 8'h00;

    // Everything the verdict stage needs about one finished datagram.
    typedef struct packed {
        logic [17:0] received;
        logic [5:0]  hdr_len;
        logic [15:0] tot_len;
        logic [16:0] sum;
        logic [7:0]  pend;
        logic [7:0]  rtype;
        logic [15:0] id;
        logic [15:0] seq;
        logic [31:0] stamp;
        logic [31:0] now;
    } t_snap;

    // RFC 1071 end-around-carry add of one 16-bit word.
    function automatic logic [16:0] ones_add(input logic [16:0] acc, input logic [15:0] word);
        logic [17:0] s;
        s = {1'b0, acc} + {2'b00, word};
        return {1'b0, s[15:0]} + {15'd0, s[17:16]};
    endfunction

endpackage

// ===== hw/rtl/icmp_echo_reply_checker.sv =====
// ICMP echo reply checker.
// The input channel (i_valid, o_stall) carries one item per datagram byte:
// i_rx_byte, i_last_byte marking the final byte, and i_now_ticks, which is
// only looked at on the final byte. An item is taken on a rising edge with
// i_valid high and o_stall low. The output channel (o_valid, i_stall) carries
// one verdict item per datagram: status, round trip, echoed sequence number
// and the running statistics (reply count, total, minimum, maximum).
// Throughput is one byte per cycle while o_stall is low. Byte bookkeeping
// is a single register stage that carries the running datagram state.
// The last byte goes from the input register through the byte stage into
// the checksum and status stage, and the verdict then enters the output
// register behind o_valid; a good verdict updates the statistics as it enters.
// When the receiver stalls, the verdict waits in the output register while
// bytes of the next datagram keep flowing in; o_stall rises only when a
// further last byte would need the full verdict path.
// A synchronous active-low reset empties the pipeline, clears the datagram
// state and the statistics (minimum to all ones), and sets expected_id to 0
// and min_icmp_length to 8. The user must write registers through i_cfg_we
// only while the block is idle; the block itself does not enforce this.
module icmp_echo_reply_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [icmperc_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [icmperc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [7:0]                           i_rx_byte,
    input  logic                                 i_last_byte,
    input  logic [31:0]                          i_now_ticks,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [2:0]                           o_status,
    output logic [31:0]                          o_trip_time,
    output logic [15:0]                          o_sequence_res,
    output logic [31:0]                          o_reply_count,
    output logic [31:0]                          o_total_time,
    output logic [31:0]                          o_min_time,
    output logic [31:0]                          o_max_time
);

    // Configuration.
    logic [15:0] r_exp_id;
    logic [6:0]  r_min_len;

    // Input register.
    logic        r_a_valid;
    logic [7:0]  r_a_byte;
    logic        r_a_last;
    logic [31:0] r_a_now;

    // Per-datagram state, cleared after every verdict.
    logic [16:0] r_pos;
    logic [5:0]  r_hl;
    logic [15:0] r_tl;
    logic [16:0] r_sum;
    logic [7:0]  r_pend;
    logic [7:0]  r_type;
    logic [15:0] r_id;
    logic [15:0] r_seq;
    logic [31:0] r_stamp;

    logic [5:0]  n_hl;
    logic [15:0] n_tl;
    logic [16:0] n_sum;
    logic [7:0]  n_pend;
    logic [7:0]  n_type;
    logic [15:0] n_id;
    logic [15:0] n_seq;
    logic [31:0] n_stamp;

    // Verdict stage.
    logic                r_b_valid;
    icmperc_pkg::t_snap  r_b;
    icmperc_pkg::t_snap  n_b;

    // Output register and running statistics.
    logic                  r_out_valid;
    icmperc_pkg::t_status  r_out_status;
    logic [31:0]           r_out_trip;
    logic [15:0]           r_out_seq;
    logic [31:0]           r_cnt;
    logic [31:0]           r_tsum;
    logic [31:0]           r_tmin;
    logic [31:0]           r_tmax;

    // Flow control. A non-final byte never needs the verdict path, so it
    // moves on even while a verdict is waiting downstream.
    logic out_free;
    logic b_move;
    logic b_free;
    logic a_fire;
    logic a_free;
    logic in_acc;

    assign out_free = !r_out_valid || !i_stall;
    assign b_move   = r_b_valid && out_free;
    assign b_free   = !r_b_valid || out_free;
    assign a_fire   = r_a_valid && (!r_a_last || b_free);
    assign a_free   = !r_a_valid || a_fire;
    assign in_acc   = i_valid && a_free;
    assign o_stall  = !a_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_id  <= '0;
            r_min_len <= icmperc_pkg::MIN_LEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                icmperc_pkg::CFG_EXPECTED_ID: begin
                    r_exp_id <= i_cfg_data[15:0];
                end
                icmperc_pkg::CFG_MIN_ICMP_LENGTH: begin
                    r_min_len <= i_cfg_data[6:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_free) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_byte <= i_rx_byte;
            r_a_last <= i_last_byte;
            r_a_now  <= i_now_ticks;
        end
    end

    // Byte bookkeeping. Header and length bytes take effect in the same step
    // that delivers them, so a header length of zero lets the ICMP part start
    // on byte zero and overlap the IP header.
    logic [16:0] rel;
    logic        in_icmp;
    logic        sum_en;

    always_comb begin
        n_hl    = r_hl;
        n_tl    = r_tl;
        n_type  = r_type;
        n_id    = r_id;
        n_seq   = r_seq;
        n_stamp = r_stamp;
        n_sum   = r_sum;
        n_pend  = r_pend;

        if (r_pos == 17'd0) begin
            n_hl = {r_a_byte[3:0], 2'b00};
        end
        if (r_pos == 17'd2) begin
            n_tl = {r_a_byte, r_tl[7:0]};
        end
        if (r_pos == 17'd3) begin
            n_tl = {r_tl[15:8], r_a_byte};
        end

        in_icmp = r_pos >= {11'd0, n_hl};
        rel     = r_pos - {11'd0, n_hl};
        sum_en  = in_icmp && ((r_pos < {1'b0, n_tl}) || (r_pos < 17'd4));

        if (in_icmp) begin
            case (rel)
                17'd0:  n_type          = r_a_byte;
                17'd4:  n_id[7:0]       = r_a_byte;
                17'd5:  n_id[15:8]      = r_a_byte;
                17'd6:  n_seq[7:0]      = r_a_byte;
                17'd7:  n_seq[15:8]     = r_a_byte;
                17'd8:  n_stamp[7:0]    = r_a_byte;
                17'd9:  n_stamp[15:8]   = r_a_byte;
                17'd10: n_stamp[23:16]  = r_a_byte;
                17'd11: n_stamp[31:24]  = r_a_byte;
                default: begin
                end
            endcase
        end

        // Byte pairs are summed little-endian: even offset is the low byte.
        if (sum_en) begin
            if (!rel[0]) begin
                n_pend = r_a_byte;
            end else begin
                n_sum = icmperc_pkg::ones_add(r_sum, {r_a_byte, r_pend});
            end
        end

        n_b.received = {1'b0, r_pos} + 18'd1;
        n_b.hdr_len  = n_hl;
        n_b.tot_len  = n_tl;
        n_b.sum      = n_sum;
        n_b.pend     = n_pend;
        n_b.rtype    = n_type;
        n_b.id       = n_id;
        n_b.seq      = n_seq;
        n_b.stamp    = n_stamp;
        n_b.now      = r_a_now;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_hl    <= '0;
            r_tl    <= '0;
            r_sum   <= '0;
            r_pend  <= '0;
            r_type  <= '0;
            r_id    <= '0;
            r_seq   <= '0;
            r_stamp <= '0;
        end else if (a_fire) begin
            if (r_a_last) begin
                r_pos   <= '0;
                r_hl    <= '0;
                r_tl    <= '0;
                r_sum   <= '0;
                r_pend  <= '0;
                r_type  <= '0;
                r_id    <= '0;
                r_seq   <= '0;
                r_stamp <= '0;
            end else begin
                if (r_pos != icmperc_pkg::POS_MAX) begin
                    r_pos <= r_pos + 17'd1;
                end
                r_hl    <= n_hl;
                r_tl    <= n_tl;
                r_sum   <= n_sum;
                r_pend  <= n_pend;
                r_type  <= n_type;
                r_id    <= n_id;
                r_seq   <= n_seq;
                r_stamp <= n_stamp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (a_fire && r_a_last) begin
            r_b_valid <= 1'b1;
        end else if (b_move) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_fire && r_a_last) begin
            r_b <= n_b;
        end
    end

    // Verdict. An odd ICMP length leaves its final byte pending; it is folded
    // in alone as a low byte. The header length is always a multiple of four,
    // so the parity of the ICMP length is the parity of the total length.
    logic [17:0]          min_total;
    logic                 too_short;
    logic                 truncated;
    logic                 odd_tail;
    logic [16:0]          final_sum;
    logic                 csum_bad;
    logic [31:0]          trip;
    icmperc_pkg::t_status status;

    always_comb begin
        min_total = {12'd0, r_b.hdr_len} + {11'd0, r_min_len};
        too_short = r_b.received < min_total;
        truncated = {2'b00, r_b.tot_len} > r_b.received;
        odd_tail  = ({10'd0, r_b.hdr_len} < r_b.tot_len) && r_b.tot_len[0];
        final_sum = odd_tail ? icmperc_pkg::ones_add(r_b.sum, {8'h00, r_b.pend}) : r_b.sum;
        csum_bad  = (r_b.tot_len <= {10'd0, r_b.hdr_len})
                 || ((r_b.hdr_len == 6'd0) && (r_b.tot_len < 16'd4))
                 || (final_sum != icmperc_pkg::SUM_GOOD);
        trip      = r_b.now - r_b.stamp;

        if (too_short) begin
            status = icmperc_pkg::ST_SHORT;
        end else if (truncated) begin
            status = icmperc_pkg::ST_TRUNCATED;
        end else if (csum_bad) begin
            status = icmperc_pkg::ST_CHECKSUM;
        end else if (r_b.rtype != icmperc_pkg::TYPE_ECHO_REPLY) begin
            status = icmperc_pkg::ST_NOT_REPLY;
        end else if (r_b.id != r_exp_id) begin
            status = icmperc_pkg::ST_FOREIGN_ID;
        end else begin
            status = icmperc_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_move) begin
            r_out_status <= status;
            r_out_trip   <= (status == icmperc_pkg::ST_OK) ? trip : '0;
            r_out_seq    <= r_b.seq;
        end
    end

    // Statistics change only as a good verdict enters the output register,
    // so the values shown with a waiting verdict stay put.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_tsum <= '0;
            r_tmin <= '1;
            r_tmax <= '0;
        end else if (b_move && (status == icmperc_pkg::ST_OK)) begin
            r_cnt  <= r_cnt + 32'd1;
            r_tsum <= r_tsum + trip;
            if (trip < r_tmin) begin
                r_tmin <= trip;
            end
            if (trip > r_tmax) begin
                r_tmax <= trip;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_trip_time    = r_out_trip;
    assign o_sequence_res = r_out_seq;
    assign o_reply_count  = r_cnt;
    assign o_total_time   = r_tsum;
    assign o_min_time     = r_tmin;
    assign o_max_time     = r_tmax;

endmodule

// ===== hw/rtl/icmperc_checker.sv =====
`include "assert_macros.svh"

module icmperc_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_cfg_we,
    input logic [icmperc_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input logic [icmperc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input logic                                 i_valid,
    input logic                                 o_stall,
    input logic [7:0]                           i_rx_byte,
    input logic                                 i_last_byte,
    input logic [31:0]                          i_now_ticks,
    input logic                                 o_valid,
    input logic                                 i_stall,
    input logic [2:0]                           o_status,
    input logic [31:0]                          o_trip_time,
    input logic [15:0]                          o_sequence_res,
    input logic [31:0]                          o_reply_count,
    input logic [31:0]                          o_total_time,
    input logic [31:0]                          o_min_time,
    input logic [31:0]                          o_max_time
);

    // A verdict that is held back stays offered.
    `CHK_ASSERT(a_out_hold, i_clk, i_rst_n, (o_valid && i_stall) |=> o_valid, "verdict dropped while stalled")

    // Only a good reply reports a round trip.
    `CHK_ASSERT(a_trip_zero, i_clk, i_rst_n, (o_valid && (o_status != icmperc_pkg::ST_OK)) |-> (o_trip_time == 32'd0), "trip time set on a failed verdict")

    // A good reply's trip lies within the minimum and maximum it updated.
    `CHK_ASSERT(a_trip_bounds, i_clk, i_rst_n, (o_valid && (o_status == icmperc_pkg::ST_OK)) |-> ((o_min_time <= o_trip_time) && (o_max_time >= o_trip_time)), "trip outside min/max")

    // The reply count moves only together with a verdict being shown.
    `CHK_ASSERT(a_count_with_verdict, i_clk, i_rst_n, !$stable(o_reply_count) |-> o_valid, "reply count changed without a verdict")

endmodule

bind icmp_echo_reply_checker icmperc_checker u_icmperc_checker (.*);

// ===== sim/testbench.sv =====
module testbench;

    // Slack after the last verdict before the block counts as idle.
    localparam int DRAIN_CYCLES   = 8;
    localparam int TIMEOUT_CYCLES = 3_000_000;
    localparam int RANDOM_BYTES   = 500;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_cfg_we;
    logic [icmperc_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [icmperc_pkg::CFG_DATA_W-1:0]  i_cfg_data;
    logic                                i_valid;
    logic                                o_stall;
    logic [7:0]                          i_rx_byte;
    logic                                i_last_byte;
    logic [31:0]                         i_now_ticks;
    logic                                o_valid;
    logic                                i_stall;
    logic [2:0]                          o_status;
    logic [31:0]                         o_trip_time;
    logic [15:0]                         o_sequence_res;
    logic [31:0]                         o_reply_count;
    logic [31:0]                         o_total_time;
    logic [31:0]                         o_min_time;
    logic [31:0]                         o_max_time;

    icmp_echo_reply_checker uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .i_last_byte    (i_last_byte),
        .i_now_ticks    (i_now_ticks),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_trip_time    (o_trip_time),
        .o_sequence_res (o_sequence_res),
        .o_reply_count  (o_reply_count),
        .o_total_time   (o_total_time),
        .o_min_time     (o_min_time),
        .o_max_time     (o_max_time)
    );

    // One verdict as the block should report it.
    typedef struct {
        icmperc_pkg::t_status status;
        logic [31:0]          trip;
        logic [15:0]          seq;
        logic [31:0]          count;
        logic [31:0]          total;
        logic [31:0]          tmin;
        logic [31:0]          tmax;
    } t_verdict;

    t_verdict verdicts_due[$];

    // Shadow of the datagram being received.
    logic [16:0] dg_pos;
    logic [5:0]  dg_hdr_len;
    logic [15:0] dg_tot_len;
    logic [16:0] dg_sum;
    logic [7:0]  dg_pend;
    logic [7:0]  dg_type;
    logic [15:0] dg_id;
    logic [15:0] dg_seq;
    logic [31:0] dg_stamp;

    // Shadow of the statistics, which survive from one datagram to the next.
    logic [31:0] stat_count;
    logic [31:0] stat_total;
    logic [31:0] stat_min;
    logic [31:0] stat_max;

    // Shadow of the configuration registers.
    logic [15:0] cfg_expected_id;
    logic [6:0]  cfg_min_len;

    // Bytes of the datagram about to be sent.
    logic [7:0] dgram_bytes[$];

    bit gaps_on = 1'b1;
    int errors = 0;
    int bytes_sent = 0;
    int dgrams_sent = 0;
    int verdicts_checked = 0;
    int status_seen[6];

    // Output sampling, filled at the falling edge.
    logic        out_taken;
    logic [2:0]  cap_status;
    logic [31:0] cap_trip;
    logic [15:0] cap_seq;
    logic [31:0] cap_count;
    logic [31:0] cap_total;
    logic [31:0] cap_min;
    logic [31:0] cap_max;
    t_verdict    want;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The run is bounded so a hung handshake cannot stall it forever.
    initial begin
        #(TIMEOUT_CYCLES * 10);
        $display("Test completed with failures");
        $finish;
    end

    // RFC 1071 style addition with the carry folded back into the low word.
    function automatic logic [31:0] carry_add(input logic [31:0] acc, input logic [15:0] word);
        logic [31:0] s;
        s = acc + {16'h0000, word};
        return {16'h0000, s[15:0]} + (s >> 16);
    endfunction

    task automatic clear_datagram();
        dg_pos     = '0;
        dg_hdr_len = '0;
        dg_tot_len = '0;
        dg_sum     = '0;
        dg_pend    = '0;
        dg_type    = '0;
        dg_id      = '0;
        dg_seq     = '0;
        dg_stamp   = '0;
    endtask

    // Advances the shadow by one accepted byte. On the final byte the verdict
    // that the block must produce is queued and the datagram state is cleared.
    task automatic predict_byte(input logic [7:0] b, input logic last, input logic [31:0] now);
        logic [16:0] pos;
        logic [31:0] rel;
        logic [31:0] received;
        logic [31:0] need;
        logic [31:0] sum;
        logic [31:0] trip;
        logic        bad;
        t_verdict    v;
        pos  = dg_pos;
        trip = '0;
        // Header fields come first, so a header length of zero makes byte 0
        // the ICMP type as well.
        if (pos == 0)
            dg_hdr_len = {b[3:0], 2'b00};
        else if (pos == 2)
            dg_tot_len[15:8] = b;
        else if (pos == 3)
            dg_tot_len[7:0] = b;

        if (pos >= dg_hdr_len) begin
            rel = 32'(pos) - 32'(dg_hdr_len);
            if (rel == 0)
                dg_type = b;
            else if (rel == 4)
                dg_id[7:0] = b;
            else if (rel == 5)
                dg_id[15:8] = b;
            else if (rel == 6)
                dg_seq[7:0] = b;
            else if (rel == 7)
                dg_seq[15:8] = b;
            else if (rel >= 8 && rel <= 11)
                dg_stamp[(rel - 8) * 8 +: 8] = b;
            // Bytes past the total length are padding and stay out of the sum.
            if (pos < dg_tot_len || pos < 4) begin
                if (!rel[0])
                    dg_pend = b;
                else
                    dg_sum = 17'(carry_add(32'(dg_sum), {b, dg_pend}));
            end
        end

        if (!last) begin
            if (dg_pos < icmperc_pkg::POS_MAX)
                dg_pos = dg_pos + 1'b1;
        end else begin
            received = 32'(pos) + 1;
            need     = 32'(dg_hdr_len) + 32'(cfg_min_len);
            if (received < need) begin
                v.status = icmperc_pkg::ST_SHORT;
            end else if (32'(dg_tot_len) > received) begin
                v.status = icmperc_pkg::ST_TRUNCATED;
            end else begin
                sum = 32'(dg_sum);
                // An odd ICMP length leaves its last byte alone in the low lane.
                if (dg_tot_len > dg_hdr_len && dg_tot_len[0] != dg_hdr_len[0])
                    sum = carry_add(sum, {8'h00, dg_pend});
                bad = (dg_tot_len <= dg_hdr_len) || (dg_hdr_len == 0 && dg_tot_len < 4) ||
                      (sum != 32'(icmperc_pkg::SUM_GOOD));
                if (bad) begin
                    v.status = icmperc_pkg::ST_CHECKSUM;
                end else if (dg_type != icmperc_pkg::TYPE_ECHO_REPLY) begin
                    v.status = icmperc_pkg::ST_NOT_REPLY;
                end else if (dg_id != cfg_expected_id) begin
                    v.status = icmperc_pkg::ST_FOREIGN_ID;
                end else begin
                    v.status   = icmperc_pkg::ST_OK;
                    trip       = now - dg_stamp;
                    stat_count = stat_count + 1;
                    stat_total = stat_total + trip;
                    if (trip < stat_min)
                        stat_min = trip;
                    if (trip > stat_max)
                        stat_max = trip;
                end
            end
            v.trip  = trip;
            v.seq   = dg_seq;
            v.count = stat_count;
            v.total = stat_total;
            v.tmin  = stat_min;
            v.tmax  = stat_max;
            verdicts_due.push_back(v);
            clear_datagram();
        end
    endtask

    // Sender idle time: mostly back to back, sometimes a short pause, rarely a long one.
    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 2);
        else if (r < 97)
            return $urandom_range(3, 6);
        else
            return $urandom_range(10, 30);
    endfunction

    // Offers one item and holds it until the block takes it. The decision is
    // made at the falling edge, once everything driven at the rising edge has
    // settled, and the item counts as taken at the rising edge that follows.
    task automatic send_byte(input logic [7:0] b, input logic last, input logic [31:0] now);
        logic taken;
        int   gap;
        i_valid     <= 1'b1;
        i_rx_byte   <= b;
        i_last_byte <= last;
        i_now_ticks <= now;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !o_stall;
            if (taken)
                predict_byte(b, last, now);
            @(posedge i_clk);
        end
        bytes_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Sends the prepared datagram; the tick only matters on the final byte,
    // the other bytes carry random ticks.
    task automatic send_frame(input logic [31:0] now);
        int  i;
        int  n;
        n = dgram_bytes.size();
        for (i = 0; i < n; i++)
            send_byte(dgram_bytes[i], i == n - 1, (i == n - 1) ? now : 32'($urandom));
        dgrams_sent++;
    endtask

    // Lets every outstanding verdict arrive, then waits out DRAIN_CYCLES.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [icmperc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == icmperc_pkg::CFG_EXPECTED_ID)
            cfg_expected_id = data;
        else
            cfg_min_len = data[6:0];
        @(posedge i_clk);
    endtask

    // Fills in the checksum word at the given ICMP offset so that the ones
    // complement sum over the ICMP part comes out as all ones.
    task automatic seal_checksum(input int slot);
        int          hl;
        int          tl;
        int          rel;
        logic [31:0] acc;
        logic [15:0] w;
        logic [15:0] c;
        hl = int'(dgram_bytes[0][3:0]) * 4;
        tl = int'({dgram_bytes[2], dgram_bytes[3]});
        dgram_bytes[hl + slot]     = 8'h00;
        dgram_bytes[hl + slot + 1] = 8'h00;
        acc = '0;
        for (rel = 0; hl + rel < tl; rel += 2) begin
            w = {8'h00, dgram_bytes[hl + rel]};
            if (hl + rel + 1 < tl)
                w[15:8] = dgram_bytes[hl + rel + 1];
            acc = carry_add(acc, w);
        end
        c = ~acc[15:0];
        dgram_bytes[hl + slot]     = c[7:0];
        dgram_bytes[hl + slot + 1] = c[15:8];
    endtask

    // Builds a well-formed reply of the given type with random filler in the other fields.
    task automatic build_reply(input int hl_nib, input int msg_len, input logic [7:0] rtype,
                               input logic [15:0] id, input logic [15:0] seq,
                               input logic [31:0] stamp);
        int         hl;
        int         tl;
        int         i;
        int         rel;
        logic [7:0] v;
        hl = hl_nib * 4;
        tl = hl + msg_len;
        dgram_bytes.delete();
        for (i = 0; i < tl; i++) begin
            v   = 8'($urandom);
            rel = i - hl;
            if (i == 0)
                v = {v[7:4], hl_nib[3:0]};
            else if (i == 2)
                v = tl[15:8];
            else if (i == 3)
                v = tl[7:0];
            else if (rel == 0)
                v = rtype;
            else if (rel == 4)
                v = id[7:0];
            else if (rel == 5)
                v = id[15:8];
            else if (rel == 6)
                v = seq[7:0];
            else if (rel == 7)
                v = seq[15:8];
            else if (rel >= 8 && rel <= 11)
                v = stamp[(rel - 8) * 8 +: 8];
            dgram_bytes.push_back(v);
        end
        seal_checksum(2);
    endtask

    task automatic compare_field(input string what, input logic [31:0] expv,
                                 input logic [31:0] actv);
        if (expv !== actv) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, expv, actv);
            errors++;
        end
    endtask

    // Receiver stall: random bursts of mostly short stalls, now and then a
    // long one, with calm stretches where every verdict is taken at once.
    initial begin : out_stall_gen
        int r;
        i_stall = 1'b0;
        @(posedge i_clk);
        forever begin
            r = $urandom_range(0, 9);
            if (r == 0) begin
                i_stall <= 1'b0;
                repeat ($urandom_range(20, 80)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b1;
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
                        $urandom_range(1, 3)) @(posedge i_clk);
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    // Verdict checker. Outputs are sampled at the falling edge and the item
    // counts at the next rising edge, where it is matched with the oldest
    // expectation field by field.
    always begin
        @(negedge i_clk);
        out_taken  = i_rst_n && o_valid && !i_stall;
        cap_status = o_status;
        cap_trip   = o_trip_time;
        cap_seq    = o_sequence_res;
        cap_count  = o_reply_count;
        cap_total  = o_total_time;
        cap_min    = o_min_time;
        cap_max    = o_max_time;
        @(posedge i_clk);
        if (out_taken) begin
            if (verdicts_due.size() == 0) begin
                $display("%0t: verdict with no datagram pending, expected none, actual status %0d",
                         $time, cap_status);
                errors++;
            end else begin
                want = verdicts_due.pop_front();
                compare_field("status", 32'(want.status), 32'(cap_status));
                compare_field("trip_time", want.trip, cap_trip);
                compare_field("sequence", 32'(want.seq), 32'(cap_seq));
                compare_field("reply_count", want.count, cap_count);
                compare_field("total_time", want.total, cap_total);
                compare_field("min_time", want.tmin, cap_min);
                compare_field("max_time", want.tmax, cap_max);
                status_seen[int'(want.status)]++;
                verdicts_checked++;
            end
        end
    end

    // Reset values of both registers: identifier 0 and a minimum of 8 ICMP
    // bytes, so one byte less than that is short even though it is also
    // truncated.
    task automatic test_reset_defaults();
        build_reply(5, 8, icmperc_pkg::TYPE_ECHO_REPLY, 16'h0000, 16'h0001, 32'h0);
        send_frame($urandom);
        build_reply(5, 8, icmperc_pkg::TYPE_ECHO_REPLY, 16'h0000, 16'h0002, 32'h0);
        void'(dgram_bytes.pop_back());
        send_frame($urandom);
    endtask

    // One datagram for each verdict, and the order in which checks win.
    task automatic test_verdict_order();
        logic [31:0] stamp;
        int          hl;
        wait_idle();
        write_reg(icmperc_pkg::CFG_EXPECTED_ID, 16'hA5C3);
        write_reg(icmperc_pkg::CFG_MIN_ICMP_LENGTH, 16'd8);
        hl    = 20;
        stamp = $urandom;
        // Good reply with a stamp, then an odd ICMP length.
        build_reply(5, 12, icmperc_pkg::TYPE_ECHO_REPLY, 16'hA5C3, 16'h1111, stamp);
        send_frame(stamp + 37);
        build_reply(5, 13, icmperc_pkg::TYPE_ECHO_REPLY, 16'hA5C3, 16'h2222, stamp);
        send_frame(stamp + 1000);
        // Padding after the total length is neither summed nor an error.
        build_reply(5, 10, icmperc_pkg::TYPE_ECHO_REPLY, 16'hA5C3, 16'h3333, stamp);
        repeat (3) dgram_bytes.push_back(8'($urandom));
        send_frame($urandom);
        // A corrupted byte in the ICMP part.
        build_reply(5, 16, icmperc_pkg::TYPE_ECHO_REPLY, 16'hA5C3, 16'h4444, stamp);
        dgram_bytes[hl + 9] ^= 8'h5A;
        send_frame($urandom);
        // Echo request instead of a reply, then a foreign identifier.
        build_reply(5, 12, 8'h08, 16'hA5C3, 16'h5555, stamp);
        send_frame($urandom);
        build_reply(5, 12, icmperc_pkg::TYPE_ECHO_REPLY, 16'hA5C2, 16'h6666, stamp);
        send_frame($urandom);
        // Total length beyond the received bytes, once mildly and once at the maximum.
        build_reply(5, 20, icmperc_pkg::TYPE_ECHO_REPLY, 16'hA5C3, 16'h7777, stamp);
        repeat (4) void'(dgram_bytes.pop_back());
        send_frame($urandom);
        build_reply(5, 12, icmperc_pkg::TYPE_ECHO_REPLY, 16'hA5C3, 16'hFFFF, stamp);
        dgram_bytes[2] = 8'hFF;
        dgram_bytes[3] = 8'hFF;
        send_frame($urandom);
        // Empty ICMP part: total length equal to the header length.
        build_reply(5, 12, icmperc_pkg::TYPE_ECHO_REPLY, 16'hA5C3, 16'h8888, stamp);
        dgram_bytes[2] = 8'h00;
        dgram_bytes[3] = 8'd20;
        send_frame($urandom);
        // A bad checksum outranks a wrong type.
        build_reply(5, 12, 8'h08, 16'h0000, 16'h9999, stamp);
        dgram_bytes[hl + 1] ^= 8'h01;
        send_frame($urandom);
        // A single byte datagram is short.
        dgram_bytes.delete();
        dgram_bytes.push_back(8'($urandom));
        send_frame($urandom);
    endtask

    // A minimum ICMP length of 64, at and just below the boundary.
    task automatic test_min_length_bounds();
        wait_idle();
        write_reg(icmperc_pkg::CFG_MIN_ICMP_LENGTH, 16'd64);
        build_reply(5, 64, icmperc_pkg::TYPE_ECHO_REPLY, cfg_expected_id, 16'h0101,
                    32'($urandom));
        void'(dgram_bytes.pop_back());
        send_frame($urandom);
        build_reply(5, 64, icmperc_pkg::TYPE_ECHO_REPLY, cfg_expected_id, 16'h0202,
                    32'hDEADBEEF);
        send_frame(32'hDEADBEEF + 32'd500);
    endtask

    // Header length of zero: the ICMP part starts at byte 0 and shares the
    // length field with the IP header.
    task automatic test_header_overlap();
        int i;
        wait_idle();
        write_reg(icmperc_pkg::CFG_MIN_ICMP_LENGTH, 16'd8);
        write_reg(icmperc_pkg::CFG_EXPECTED_ID, 16'h3C5A);
        // Total length below four gives a checksum failure, even and odd.
        dgram_bytes.delete();
        repeat (12) dgram_bytes.push_back(8'($urandom));
        dgram_bytes[0] = {dgram_bytes[0][7:4], 4'h0};
        dgram_bytes[2] = 8'h00;
        dgram_bytes[3] = 8'd2;
        send_frame($urandom);
        dgram_bytes[3] = 8'd3;
        send_frame($urandom);
        // A reply that passes every check with type and header length in
        // byte 0 and the checksum word moved into the payload.
        dgram_bytes.delete();
        for (i = 0; i < 16; i++)
            dgram_bytes.push_back(8'($urandom));
        dgram_bytes[0] = icmperc_pkg::TYPE_ECHO_REPLY;
        dgram_bytes[2] = 8'h00;
        dgram_bytes[3] = 8'd16;
        dgram_bytes[4] = 8'h5A;
        dgram_bytes[5] = 8'h3C;
        seal_checksum(12);
        send_frame($urandom);
    endtask

    // Mostly well-formed replies with random content; the rest are broken
    // on purpose or plain noise.
    task automatic random_datagram();
        int          kind;
        int          hl_nib;
        int          msg_len;
        int          hl;
        logic [7:0]  rtype;
        logic [15:0] id;
        logic [31:0] stamp;
        logic [31:0] now;
        gaps_on  = ($urandom_range(0, 4) != 0);
        hl_nib   = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 15) : $urandom_range(1, 6);
        hl       = hl_nib * 4;
        msg_len  = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 72) :
                   int'(cfg_min_len) + $urandom_range(0, 12);
        id       = cfg_expected_id;
        rtype    = icmperc_pkg::TYPE_ECHO_REPLY;
        stamp    = $urandom;
        now      = ($urandom_range(0, 3) == 0) ? 32'($urandom) :
                   stamp + 32'($urandom_range(0, 5000));
        kind     = $urandom_range(0, 99);
        if (kind < 6) begin
            dgram_bytes.delete();
            repeat ($urandom_range(1, 48)) dgram_bytes.push_back(8'($urandom));
        end else begin
            if (kind >= 60 && kind < 68)
                rtype = 8'($urandom_range(1, 255));
            if (kind >= 68 && kind < 75)
                id = id ^ 16'($urandom_range(1, 65535));
            build_reply(hl_nib, msg_len, rtype, id, 16'($urandom), stamp);
            if (kind >= 75 && kind < 82)
                dgram_bytes[$urandom_range(hl, dgram_bytes.size() - 1)] ^=
                    8'($urandom_range(1, 255));
            else if (kind >= 82 && kind < 89)
                repeat ($urandom_range(1, msg_len)) void'(dgram_bytes.pop_back());
            else if (kind >= 89 && kind < 93)
                repeat ($urandom_range(1, 6)) dgram_bytes.push_back(8'($urandom));
            else if (kind >= 93 && kind < 97) begin
                dgram_bytes[2] = 8'($urandom);
                dgram_bytes[3] = 8'($urandom);
            end else if (kind >= 97)
                dgram_bytes[0][3:0] = 4'($urandom);
        end
        send_frame(now);
        gaps_on = 1'b1;
    endtask

    // Several register settings, the extremes first. Between settings the
    // sender waits for every verdict; now and then it also does so mid-phase.
    task automatic test_random_traffic();
        int phase;
        int start_bytes;
        int start_dgrams;
        for (phase = 0; phase < 4; phase++) begin
            wait_idle();
            case (phase)
                0: begin
                    write_reg(icmperc_pkg::CFG_EXPECTED_ID, 16'hFFFF);
                    write_reg(icmperc_pkg::CFG_MIN_ICMP_LENGTH, 16'd8);
                end
                1: begin
                    write_reg(icmperc_pkg::CFG_EXPECTED_ID, 16'h0000);
                    write_reg(icmperc_pkg::CFG_MIN_ICMP_LENGTH, 16'd64);
                end
                default: begin
                    write_reg(icmperc_pkg::CFG_EXPECTED_ID, 16'($urandom));
                    write_reg(icmperc_pkg::CFG_MIN_ICMP_LENGTH, 16'($urandom_range(8, 64)));
                end
            endcase
            start_bytes  = bytes_sent;
            start_dgrams = dgrams_sent;
            while (bytes_sent - start_bytes < RANDOM_BYTES / 4 ||
                   dgrams_sent - start_dgrams < 3) begin
                random_datagram();
                if ($urandom_range(0, 19) == 0)
                    wait_idle();
            end
        end
    endtask

    // Round trips of zero and of all ones; both stick in the minimum and
    // maximum, so they come last. The second also wraps the total.
    task automatic test_trip_extremes();
        logic [31:0] stamp;
        wait_idle();
        write_reg(icmperc_pkg::CFG_MIN_ICMP_LENGTH, 16'd8);
        stamp = $urandom;
        build_reply(5, 12, icmperc_pkg::TYPE_ECHO_REPLY, cfg_expected_id, 16'h0F0F, stamp);
        send_frame(stamp);
        build_reply(5, 12, icmperc_pkg::TYPE_ECHO_REPLY, cfg_expected_id, 16'hF0F0, stamp);
        send_frame(stamp - 32'd1);
        build_reply(5, 12, icmperc_pkg::TYPE_ECHO_REPLY, cfg_expected_id, 16'h00FF, stamp);
        send_frame(stamp + 32'd5);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_rx_byte   = '0;
        i_last_byte = 1'b0;
        i_now_ticks = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = icmperc_pkg::CFG_EXPECTED_ID;
        i_cfg_data  = '0;

        // The shadow starts from the reset state of the block.
        clear_datagram();
        stat_count      = '0;
        stat_total      = '0;
        stat_min        = '1;
        stat_max        = '0;
        cfg_expected_id = '0;
        cfg_min_len     = icmperc_pkg::MIN_LEN_RST;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_reset_defaults();
        test_verdict_order();
        test_min_length_bounds();
        test_header_overlap();
        test_random_traffic();
        test_trip_extremes();
        wait_idle();

        $display("Sent %0d bytes in %0d datagrams; %0d verdicts compared.",
                 bytes_sent, dgrams_sent, verdicts_checked);
        $display("Verdicts: ok %0d, short %0d, truncated %0d, checksum %0d, type %0d, id %0d.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5]);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
